### rtl/prmt_pkg.sv
// prmt_pkg: shared types, codes and constants for the page range merge table.
// No dependencies; used by every module under rtl/.
`default_nettype none
package prmt_pkg;

    localparam int MAX_RANGES_DEF = 16;

    localparam int DATA_W   = 64;
    localparam int SHIFT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int EIDX_W   = 4;
    localparam int EUSED_W  = 5;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_SHIFT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRACKING   = 1'd1;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

    localparam logic [STATUS_W-1:0] ST_COVERED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic covered;
        logic touch;
    } t_cmp_res;

endpackage
`default_nettype wire

### rtl/prmt_store.sv
// prmt_store: range table memory, one write port and one registered read port.
// Holds base and end (base plus size, wrapping) of each range. Uses prmt_pkg.
`default_nettype none
module prmt_store #(
    parameter int DEPTH = prmt_pkg::MAX_RANGES_DEF,
    parameter int IDX_W = 4
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [IDX_W-1:0]     i_waddr,
    input  prmt_pkg::t_word     i_wbase,
    input  prmt_pkg::t_word     i_wend,
    input  wire [IDX_W-1:0]     i_raddr,
    output prmt_pkg::t_word     o_rbase,
    output prmt_pkg::t_word     o_rend
);

    prmt_pkg::t_word r_base [DEPTH];
    prmt_pkg::t_word r_end  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_base[i_waddr] <= i_wbase;
            r_end[i_waddr]  <= i_wend;
        end
        o_rbase <= r_base[i_raddr];
        o_rend  <= r_end[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/prmt_cmp.sv
// prmt_cmp: shared compare unit; tests one stored range against the region
// and forms the union bounds. Uses prmt_pkg.
`default_nettype none
module prmt_cmp (
    input  prmt_pkg::t_word     i_start,
    input  prmt_pkg::t_word     i_end,
    input  prmt_pkg::t_word     i_cs,
    input  prmt_pkg::t_word     i_ce,
    output prmt_pkg::t_cmp_res  o_res,
    output prmt_pkg::t_word     o_ms,
    output prmt_pkg::t_word     o_me
);

    logic start_lt_cs;
    logic end_gt_ce;

    assign start_lt_cs = i_start < i_cs;
    assign end_gt_ce   = i_end > i_ce;

    assign o_res.covered = !start_lt_cs && !end_gt_ce;
    assign o_res.touch   = !((i_end < i_cs) || (i_start > i_ce));
    assign o_ms          = start_lt_cs ? i_start : i_cs;
    assign o_me          = end_gt_ce ? i_end : i_ce;

endmodule
`default_nettype wire

### rtl/page_range_merge_table.sv
// page_range_merge_table: top level; sequencer, config registers and result regs.
// Instantiates prmt_store and prmt_cmp. Uses prmt_pkg.
//
//  channel   dir  handshake                       payload
//  request   in   start & !busy                   i_region_address, i_region_length
//  result    out  o_result_valid (1-cycle strobe) o_status, o_entry_index, o_aligned_start,
//                                                 o_aligned_length, o_register_now,
//                                                 o_entries_used
//  config    in   i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
//  The strobe follows the accepting edge through the alignment arithmetic (states S_END, S_LEN),
//  then, if entries are in use, the coverage scan and the merge scan; each scan reads one
//  entry a cycle through the single table read port and the shared compare unit.
//  A new item may be accepted in the strobe cycle.
//  Reset clears the state, the entry count and the config registers; the table is not cleared.
//  The receiver cannot stall; results are never held.
`default_nettype none
module page_range_merge_table #(
    parameter int MAX_RANGES = prmt_pkg::MAX_RANGES_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire [prmt_pkg::DATA_W-1:0]            i_region_address,
    input  wire [prmt_pkg::DATA_W-1:0]            i_region_length,
    output logic                                  o_result_valid,
    output logic [prmt_pkg::STATUS_W-1:0]         o_status,
    output logic [prmt_pkg::EIDX_W-1:0]           o_entry_index,
    output logic [prmt_pkg::DATA_W-1:0]           o_aligned_start,
    output logic [prmt_pkg::DATA_W-1:0]           o_aligned_length,
    output logic                                  o_register_now,
    output logic [prmt_pkg::EUSED_W-1:0]          o_entries_used,
    input  wire                                   i_cfg_we,
    input  wire [prmt_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire [prmt_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RANGES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_END  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_COV  = 3'd3;
    localparam logic [2:0] S_MRG  = 3'd4;

    logic [2:0]                      r_state, n_state;
    logic [IDX_W-1:0]                r_ptr, n_ptr;
    logic [CNT_W-1:0]                r_used, n_used;
    logic                            r_valid, n_valid;
    logic [prmt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [IDX_W-1:0]                r_eidx, n_eidx;
    logic                            r_reg_now, n_reg_now;
    prmt_pkg::t_word                 r_start, n_start;
    prmt_pkg::t_word                 r_sum, n_sum;
    prmt_pkg::t_word                 r_end, n_end;
    prmt_pkg::t_word                 r_alen, n_alen;
    logic [prmt_pkg::SHIFT_W-1:0]    r_shift;
    logic                            r_track;

    prmt_pkg::t_word                 pmin1;
    prmt_pkg::t_word                 mask;
    logic [IDX_W-1:0]                ptr_inc;
    logic [CNT_W-1:0]                ptr_ext;
    logic                            last;

    logic                            we;
    logic [IDX_W-1:0]                waddr;
    logic [IDX_W-1:0]                raddr;
    prmt_pkg::t_word                 wbase, wend;
    prmt_pkg::t_word                 rbase, rend;
    prmt_pkg::t_cmp_res              cmp;
    prmt_pkg::t_word                 ms, me;

    logic                            fin;
    logic                            app;
    logic [prmt_pkg::STATUS_W-1:0]   fin_status;
    logic [IDX_W-1:0]                fin_idx;

    assign pmin1   = (64'd1 << r_shift) - 64'd1;
    assign mask    = ~pmin1;
    assign ptr_inc = r_ptr + 1'b1;
    assign ptr_ext = CNT_W'(r_ptr);
    assign last    = (ptr_ext + 1'b1) == r_used;

    prmt_store #(
        .DEPTH (MAX_RANGES),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wbase (wbase),
        .i_wend  (wend),
        .i_raddr (raddr),
        .o_rbase (rbase),
        .o_rend  (rend)
    );

    prmt_cmp u_cmp (
        .i_start (r_start),
        .i_end   (r_end),
        .i_cs    (rbase),
        .i_ce    (rend),
        .o_res   (cmp),
        .o_ms    (ms),
        .o_me    (me)
    );

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_used     = r_used;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_eidx     = r_eidx;
        n_reg_now  = r_reg_now;
        n_start    = r_start;
        n_sum      = r_sum;
        n_end      = r_end;
        n_alen     = r_alen;
        raddr      = r_ptr;
        we         = 1'b0;
        waddr      = r_ptr;
        wbase      = ms;
        wend       = me;
        fin        = 1'b0;
        app        = 1'b0;
        fin_status = prmt_pkg::ST_FULL;
        fin_idx    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_start = i_region_address & mask;
                    n_sum   = i_region_address + i_region_length;
                    n_state = S_END;
                end
            end
            S_END: begin
                n_end   = (r_sum + pmin1) & mask;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_alen = r_end - r_start;
                n_ptr  = '0;
                raddr  = '0;
                if (r_used == '0) begin
                    if (r_end == r_start) begin
                        fin        = 1'b1;
                        fin_status = prmt_pkg::ST_EMPTY;
                    end else begin
                        app = 1'b1;
                    end
                end else begin
                    n_state = S_COV;
                end
            end
            S_COV: begin
                raddr = ptr_inc;
                if (cmp.covered) begin
                    fin        = 1'b1;
                    fin_status = prmt_pkg::ST_COVERED;
                    fin_idx    = r_ptr;
                end else if (last) begin
                    if (r_end == r_start) begin
                        fin        = 1'b1;
                        fin_status = prmt_pkg::ST_EMPTY;
                    end else begin
                        n_ptr   = '0;
                        raddr   = '0;
                        n_state = S_MRG;
                    end
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_MRG: begin
                raddr = ptr_inc;
                if (cmp.touch) begin
                    we         = 1'b1;
                    fin        = 1'b1;
                    fin_status = prmt_pkg::ST_MERGED;
                    fin_idx    = r_ptr;
                end else if (last) begin
                    if (r_used != CNT_FULL) begin
                        app = 1'b1;
                    end else begin
                        fin        = 1'b1;
                        fin_status = prmt_pkg::ST_FULL;
                    end
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (app) begin
            we         = 1'b1;
            waddr      = r_used[IDX_W-1:0];
            wbase      = r_start;
            wend       = r_end;
            n_used     = r_used + 1'b1;
            fin        = 1'b1;
            fin_status = prmt_pkg::ST_APPENDED;
            fin_idx    = r_used[IDX_W-1:0];
        end

        if (fin) begin
            n_valid   = 1'b1;
            n_status  = fin_status;
            n_eidx    = fin_idx;
            n_reg_now = r_track && ((fin_status == prmt_pkg::ST_MERGED) ||
                                    (fin_status == prmt_pkg::ST_APPENDED));
            n_state   = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_status  <= n_status;
        r_eidx    <= n_eidx;
        r_reg_now <= n_reg_now;
        r_start   <= n_start;
        r_sum     <= n_sum;
        r_end     <= n_end;
        r_alen    <= n_alen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= prmt_pkg::PAGE_SHIFT_RST;
            r_track <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                prmt_pkg::CFG_PAGE_SHIFT: r_shift <= i_cfg_wdata[prmt_pkg::SHIFT_W-1:0];
                prmt_pkg::CFG_TRACKING:   r_track <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign busy             = r_state != S_IDLE;
    assign o_result_valid   = r_valid;
    assign o_status         = r_status;
    assign o_entry_index    = prmt_pkg::EIDX_W'(r_eidx);
    assign o_aligned_start  = r_start;
    assign o_aligned_length = r_alen;
    assign o_register_now   = r_reg_now;
    assign o_entries_used   = prmt_pkg::EUSED_W'(r_used);

endmodule
`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for page_range_merge_table, the page-aligned range merge table.
// Runs directed and random items against its own table model; depends on prmt_pkg
// and the block under rtl/.
`default_nettype none
module tb;

    typedef struct {
        prmt_pkg::t_word addr;
        prmt_pkg::t_word len;
        bit              calm;
    } t_region_item;

    typedef struct packed {
        logic [prmt_pkg::STATUS_W-1:0] status;
        logic [prmt_pkg::EIDX_W-1:0]   idx;
        prmt_pkg::t_word               a_start;
        prmt_pkg::t_word               a_len;
        logic                          reg_now;
        logic [prmt_pkg::EUSED_W-1:0]  used;
    } t_page_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    prmt_pkg::t_word                 i_region_address = '0;
    prmt_pkg::t_word                 i_region_length = '0;
    logic                            o_result_valid;
    logic [prmt_pkg::STATUS_W-1:0]   o_status;
    logic [prmt_pkg::EIDX_W-1:0]     o_entry_index;
    prmt_pkg::t_word                 o_aligned_start;
    prmt_pkg::t_word                 o_aligned_length;
    logic                            o_register_now;
    logic [prmt_pkg::EUSED_W-1:0]    o_entries_used;
    logic                            i_cfg_we = 1'b0;
    logic [prmt_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [prmt_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    page_range_merge_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_region_address(i_region_address),
        .i_region_length (i_region_length),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_aligned_start (o_aligned_start),
        .o_aligned_length(o_aligned_length),
        .o_register_now  (o_register_now),
        .o_entries_used  (o_entries_used),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_region_item    region_q[$];
    t_page_result    pending_results[$];
    int              n_queued = 0;
    int              n_accepted = 0;
    int              n_results = 0;
    int              n_errors = 0;
    logic            req_taken = 1'b0;
    int              gap_left = 0;
    prmt_pkg::t_word anchor[16];

    // model of the table
    prmt_pkg::t_word                 tbl_base[prmt_pkg::MAX_RANGES_DEF];
    prmt_pkg::t_word                 tbl_size[prmt_pkg::MAX_RANGES_DEF];
    int                              n_used = 0;
    logic [prmt_pkg::SHIFT_W-1:0]    cfg_shift = prmt_pkg::PAGE_SHIFT_RST;
    logic                            cfg_track = 1'b0;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic t_page_result track_region(input prmt_pkg::t_word addr,
                                                  input prmt_pkg::t_word len);
        prmt_pkg::t_word mask;
        prmt_pkg::t_word pstart;
        prmt_pkg::t_word pend;
        prmt_pkg::t_word cs;
        prmt_pkg::t_word ce;
        t_page_result    r;
        bit              done;
        mask = ~((64'd1 << cfg_shift) - 64'd1);
        pstart = addr & mask;
        pend = (addr + len + ~mask) & mask;
        r = '0;
        r.a_start = pstart;
        r.a_len = pend - pstart;
        r.status = prmt_pkg::ST_FULL;
        done = 1'b0;
        for (int i = 0; i < n_used && !done; i++) begin
            cs = tbl_base[i];
            ce = cs + tbl_size[i];
            if (pstart >= cs && pend <= ce) begin
                r.status = prmt_pkg::ST_COVERED;
                r.idx = prmt_pkg::EIDX_W'(i);
                done = 1'b1;
            end
        end
        // coverage wins over emptiness
        if (!done && r.a_len == '0) begin
            r.status = prmt_pkg::ST_EMPTY;
            done = 1'b1;
        end
        // first touching entry only, no chained merges
        for (int i = 0; i < n_used && !done; i++) begin
            cs = tbl_base[i];
            ce = cs + tbl_size[i];
            if (!(pend < cs || pstart > ce)) begin
                tbl_base[i] = (pstart < cs) ? pstart : cs;
                tbl_size[i] = ((pend > ce) ? pend : ce) - tbl_base[i];
                r.status = prmt_pkg::ST_MERGED;
                r.idx = prmt_pkg::EIDX_W'(i);
                done = 1'b1;
            end
        end
        if (!done && n_used < prmt_pkg::MAX_RANGES_DEF) begin
            tbl_base[n_used] = pstart;
            tbl_size[n_used] = r.a_len;
            r.idx = prmt_pkg::EIDX_W'(n_used);
            n_used++;
            r.status = prmt_pkg::ST_APPENDED;
        end
        r.reg_now = cfg_track && (r.status == prmt_pkg::ST_MERGED ||
                                  r.status == prmt_pkg::ST_APPENDED);
        r.used = prmt_pkg::EUSED_W'(n_used);
        return r;
    endfunction

    // monitor: result check, prediction on accept, config tracking
    always @(posedge i_clk) begin
        t_page_result got;
        t_page_result want;
        if (!i_rst_n) begin
            cfg_shift = prmt_pkg::PAGE_SHIFT_RST;
            cfg_track = 1'b0;
            n_used = 0;
            req_taken <= 1'b0;
        end else begin
            if (o_result_valid !== 1'b0) begin
                got = '{o_status, o_entry_index, o_aligned_start, o_aligned_length,
                        o_register_now, o_entries_used};
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with no item outstanding");
                end else begin
                    want = pending_results.pop_front();
                    n_results <= n_results + 1;
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d", got.status,
                                                want.status));
                    if (got.idx !== want.idx)
                        flag_mismatch($sformatf("entry_index %0d, want %0d", got.idx,
                                                want.idx));
                    if (got.a_start !== want.a_start)
                        flag_mismatch($sformatf("aligned_start %h, want %h", got.a_start,
                                                want.a_start));
                    if (got.a_len !== want.a_len)
                        flag_mismatch($sformatf("aligned_length %h, want %h", got.a_len,
                                                want.a_len));
                    if (got.reg_now !== want.reg_now)
                        flag_mismatch($sformatf("register_now %b, want %b", got.reg_now,
                                                want.reg_now));
                    if (got.used !== want.used)
                        flag_mismatch($sformatf("entries_used %0d, want %0d", got.used,
                                                want.used));
                end
            end
            if (start && !busy) begin
                pending_results.push_back(track_region(i_region_address, i_region_length));
                n_accepted <= n_accepted + 1;
            end
            req_taken <= start && !busy;
            if (i_cfg_we) begin
                if (i_cfg_addr == prmt_pkg::CFG_PAGE_SHIFT)
                    cfg_shift = i_cfg_wdata;
                else if (i_cfg_addr == prmt_pkg::CFG_TRACKING)
                    cfg_track = i_cfg_wdata[0];
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_region_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (!start || req_taken) begin
            if (gap_left != 0 || region_q.size() == 0) begin
                start <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                i_region_address <= {$urandom, $urandom};
                i_region_length <= {$urandom, $urandom};
            end else begin
                it = region_q.pop_front();
                i_region_address <= it.addr;
                i_region_length <= it.len;
                start <= 1'b1;
                if (!it.calm && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 9);
            end
        end
    end

    function automatic void queue_region(input prmt_pkg::t_word addr,
                                         input prmt_pkg::t_word len, input bit calm);
        region_q.push_back('{addr, len, calm});
        n_queued++;
    endfunction

    function automatic void queue_random_region(input int sh, input bit calm);
        prmt_pkg::t_word pg;
        prmt_pkg::t_word a;
        prmt_pkg::t_word l;
        int              kind;
        pg = 64'd1 << sh;
        kind = $urandom_range(0, 99);
        a = anchor[$urandom_range(0, 15)] + pg * $urandom_range(0, 8) - pg * 4
            + (prmt_pkg::t_word'($urandom) & (pg - 64'd1));
        if (kind < 55) begin
            l = pg * $urandom_range(0, 6) + (prmt_pkg::t_word'($urandom) & (pg - 64'd1));
        end else if (kind < 65) begin
            l = '0;
        end else if (kind < 80) begin
            a = {$urandom, $urandom};
            l = {$urandom, $urandom};
        end else if (kind < 90) begin
            l = prmt_pkg::t_word'({$urandom, $urandom}) >> $urandom_range(20, 63);
        end else begin
            a = {$urandom, $urandom};
            l = pg * $urandom_range(0, 3);
        end
        queue_region(a, l, calm);
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (n_accepted != n_queued || n_results != n_accepted)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [prmt_pkg::CFG_ADDR_W-1:0] a,
                             input logic [prmt_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [prmt_pkg::SHIFT_W-1:0] shift_set[7];
        logic                         track_set[7];
        shift_set = '{5'd12, 5'd0, 5'd31, 5'd30, 5'd5, 5'd20, 5'd12};
        track_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        anchor[0] = 64'h1000;
        anchor[1] = 64'h10000;
        anchor[2] = 64'hFFFF_FFFF_FFFF_E000;
        anchor[3] = 64'h4000_0000_0000_0000;
        for (int k = 4; k < 16; k++)
            anchor[k] = {$urandom, $urandom};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 4 KiB pages, tracking off
        queue_region(64'h0, 64'h0, 1'b0);
        queue_region(64'h1234, 64'h10, 1'b0);
        queue_region(64'h1800, 64'h100, 1'b0);
        queue_region(64'h1100, 64'h0, 1'b0);
        queue_region(64'h2000, 64'h1000, 1'b0);
        queue_region(64'h10000, 64'h1, 1'b0);
        queue_region(64'h0, 64'h800, 1'b0);
        queue_region(64'h2000, 64'hF000, 1'b0);
        queue_region(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_region(64'hFFFF_FFFF_FFFF_E000, 64'h1000, 1'b0);
        queue_region(64'hFFFF_FFFF_FFFF_F800, 64'h1000, 1'b0);
        queue_region(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_region(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        wait_drained();

        cfg_write(prmt_pkg::CFG_TRACKING, 5'd1);
        cfg_write(prmt_pkg::CFG_PAGE_SHIFT, 5'd31);
        queue_region(64'h1_0000_0000, 64'h5, 1'b0);
        queue_region(64'h1_8000_0000, 64'h8000_0000, 1'b0);
        queue_region(64'h1_2345_6789, 64'h0, 1'b0);
        queue_region(64'h7FFF_FFFF, 64'h1, 1'b0);
        wait_drained();

        cfg_write(prmt_pkg::CFG_PAGE_SHIFT, 5'd0);
        queue_region(64'h3, 64'h0, 1'b0);
        queue_region(64'h4000_0000_0000_0001, 64'h2, 1'b0);
        queue_region(64'h4000_0000_0000_0003, 64'h4, 1'b0);
        queue_region(64'h4000_0000_0000_0010, 64'h0, 1'b0);
        queue_region(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            cfg_write(prmt_pkg::CFG_PAGE_SHIFT, shift_set[p]);
            cfg_write(prmt_pkg::CFG_TRACKING, {4'd0, track_set[p]});
            for (int n = 0; n < 122; n++)
                queue_random_region(shift_set[p], p == 6);
            wait_drained();
        end

        repeat (40) @(negedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("items left without a result");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
